// ===== rtl/core/fik_pkg.sv =====
// shared types, constants and helpers for the fabrik solver
package fik_pkg;

  localparam int unsigned MaxLinks  = 16;
  localparam int unsigned IdxW      = $clog2(MaxLinks);
  localparam int unsigned CoordW    = 24;
  localparam int unsigned LenW      = 14;
  localparam int unsigned MagW      = 30;
  localparam int unsigned SumW      = 62;
  localparam int unsigned RootW     = 31;
  localparam int unsigned DivW      = 45;
  localparam int unsigned QuotW     = 17;
  localparam int unsigned WideW     = CoordW + 2;
  localparam int unsigned SqrtSteps = SumW / 2;

  typedef enum logic [0:0] {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } arith_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PIN, S_RD_A, S_RD_K, S_DIFF, S_NORM, S_SQ, S_SQRT, S_SQRT_W,
    S_DMUL, S_DST, S_DIV_W, S_WR, S_OUT_RD, S_OUT_LD, S_OUT_W
  } state_e;

  typedef enum logic [2:0] {
    REG_LINK_COUNT = 3'd0,
    REG_LINK_LEN   = 3'd1,
    REG_ITER       = 3'd2,
    REG_BASE_X     = 3'd3,
    REG_BASE_Y     = 3'd4,
    REG_BASE_Z     = 3'd5
  } reg_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } joint_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    joint_t          data;
  } joint_wr_t;

  typedef struct packed {
    logic            en;
    joint_t          base;
    logic [LenW-1:0] len;
  } rebuild_t;

  // saturate a widened coordinate to the signed coordinate range
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
    lo = -WideW'(64'sd1 <<< (CoordW - 1));
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

endpackage

// ===== rtl/core/fik_arith.sv =====
// shared iterative unit: integer square root and restoring division
module fik_arith (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fik_pkg::arith_req_t            req_i,
  input  logic [fik_pkg::SumW-1:0]       opa_i,
  input  logic [fik_pkg::RootW-1:0]      opb_i,
  output logic                           done_o,
  output logic [fik_pkg::DivW-1:0]       res_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  fik_pkg::arith_op_e            op_q, op_d;
  logic [5:0]                    cnt_q, cnt_d;
  logic [fik_pkg::SumW-1:0]      acc_q, acc_d;
  logic [fik_pkg::SumW-1:0]      r_q, r_d;
  logic [fik_pkg::SumW-1:0]      bit_q, bit_d;
  logic [fik_pkg::RootW-1:0]     dvs_q, dvs_d;
  logic [fik_pkg::SumW-1:0]      trial;
  logic [fik_pkg::RootW+1:0]     rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    r_d    = r_q;
    bit_d  = bit_q;
    dvs_d  = dvs_q;
    trial  = r_q + bit_q;
    rem_sh = {r_q[fik_pkg::RootW:0], acc_q[fik_pkg::DivW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = opa_i;
      r_d    = '0;
      dvs_d  = opb_i;
      bit_d  = fik_pkg::SumW'(1) << (fik_pkg::SumW - 2);
      cnt_d  = (req_i.op == fik_pkg::OP_SQRT) ? 6'(fik_pkg::SqrtSteps) : 6'(fik_pkg::DivW);
    end else if (busy_q) begin
      unique case (op_q)
        fik_pkg::OP_SQRT: begin
          if (acc_q >= trial) begin
            acc_d = acc_q - trial;
            r_d   = (r_q >> 1) + bit_q;
          end else begin
            r_d   = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
        fik_pkg::OP_DIV: begin
          // shift one dividend bit into the remainder, quotient bits enter at the bottom
          if (rem_sh >= {2'b00, dvs_q}) begin
            r_d   = fik_pkg::SumW'(rem_sh - {2'b00, dvs_q});
            acc_d = {acc_q[fik_pkg::SumW-2:0], 1'b1};
          end else begin
            r_d   = fik_pkg::SumW'(rem_sh);
            acc_d = {acc_q[fik_pkg::SumW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= fik_pkg::OP_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == fik_pkg::OP_SQRT) ? r_q[fik_pkg::DivW-1:0]
                                             : acc_q[fik_pkg::DivW-1:0];

endmodule

// ===== rtl/core/fik_jmem.sv =====
// joint position store with per-entry valid bits and straight-chain fallback
module fik_jmem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fik_pkg::joint_wr_t          wr_i,
  input  fik_pkg::rebuild_t           rb_i,
  input  logic [fik_pkg::IdxW-1:0]    rd_addr_i,
  output fik_pkg::joint_t             rd_data_o
);

  fik_pkg::joint_t                 mem [fik_pkg::MaxLinks];
  logic [fik_pkg::MaxLinks-1:0]    valid_q;
  fik_pkg::joint_t                 rb_base_q;
  logic [fik_pkg::LenW-1:0]        rb_len_q;
  fik_pkg::joint_t                 rd_q;
  logic                            rd_ok_q;
  logic [fik_pkg::IdxW-1:0]        rd_idx_q;
  logic [fik_pkg::IdxW+fik_pkg::LenW-1:0] off;
  logic signed [fik_pkg::WideW-1:0]       y_wide;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q     <= mem[rd_addr_i];
    rd_idx_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rb_base_q <= '0;
      rb_len_q  <= fik_pkg::LenW'(4096);
      rd_ok_q   <= 1'b0;
    end else begin
      rd_ok_q <= valid_q[rd_addr_i];
      if (rb_i.en) begin
        valid_q   <= '0;
        rb_base_q <= rb_i.base;
        rb_len_q  <= rb_i.len;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  // an unwritten entry reads as its place on the straight chain
  always_comb begin
    off    = (fik_pkg::IdxW+fik_pkg::LenW)'(rd_idx_q) * (fik_pkg::IdxW+fik_pkg::LenW)'(rb_len_q);
    y_wide = fik_pkg::WideW'(rb_base_q.y)
           + $signed(fik_pkg::WideW'({1'b0, off}));
    if (rd_ok_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o.x = rb_base_q.x;
      rd_data_o.y = fik_pkg::sat_coord(y_wide);
      rd_data_o.z = rb_base_q.z;
    end
  end

endmodule

// ===== rtl/core/fabrik_ik_solver.sv =====
// fabrik inverse kinematics solver top level: registers, sequencer and output stage
//
// Usage:
//   s_axis carries one target point per transaction; tdata holds target_x,
//   target_y, target_z (Q12.12). tready is high only while the solver is idle.
//   m_axis returns one transaction per joint in use, base first; tdata holds
//   joint_index, pos_x, pos_y, pos_z and tlast marks the final joint.
//   The APB port holds link_count, link_length, iteration_count and the base
//   point at byte addresses 0, 4, ... 20; writing link_count or link_length
//   rebuilds the chain straight up the y axis at once (no clearing pass).
// Sequence:
//   each joint pull reads the anchor and the joint, takes their difference,
//   normalizes it, squares and sums the axes, takes the square root in the
//   shared sqrt/divide unit, then scales each axis by the link length over
//   the root with a rounded division in the same unit; a pull with no offset
//   copies the anchor. One item is solved at a time.
// Reset puts the chain straight up from the origin with three joints,
//   unit links and ten iterations. When the receiver stalls the current
//   joint holds in the output register and the sequencer waits.
module fabrik_ik_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // target_x, target_y, target_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // joint_index, pos_x, pos_y, pos_z, zero fill
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = fik_pkg::CoordW;
  localparam int unsigned IW = fik_pkg::IdxW;
  localparam int unsigned MW = fik_pkg::MagW;

  fik_pkg::state_e state_q, state_d;

  logic [4:0]            link_count_q;
  logic [13:0]           link_len_q;
  logic [4:0]            iter_q;
  fik_pkg::joint_t       base_q;
  logic                  cfg_wr;
  logic [2:0]            reg_idx;

  logic [4:0]            n_act;
  logic [IW-1:0]         last_idx;
  logic [4:0]            iters_act;

  logic                  fwd_q;
  logic [IW-1:0]         idx_q;
  logic [4:0]            it_q;
  logic [1:0]            j_q;
  fik_pkg::joint_t       tgt_q;
  fik_pkg::joint_t       a_q;
  logic [MW-1:0]         mag_q [3];
  logic [2:0]            neg_q;
  logic                  zero_q;
  logic [2*MW-1:0]       prod_q;
  logic [fik_pkg::SumW-1:0]  sum_q;
  logic [fik_pkg::RootW-1:0] root_q;
  logic [fik_pkg::QuotW-1:0] quo_q [3];

  logic [IW-1:0]         out_idx_q;
  fik_pkg::joint_t       out_pos_q;
  logic                  out_last_q;

  fik_pkg::joint_wr_t    jwr;
  fik_pkg::rebuild_t     rb;
  logic [IW-1:0]         rd_addr;
  fik_pkg::joint_t       rd_data;
  fik_pkg::arith_req_t   areq;
  logic [fik_pkg::SumW-1:0]  a_opa;
  logic                  a_done;
  logic [fik_pkg::DivW-1:0]  a_res;

  logic [IW-1:0]         k_idx, a_idx;
  logic [MW-1:0]         mag_sel, mul_b;
  logic signed [CW:0]    dx, dy, dz;
  fik_pkg::joint_t       new_pos;
  logic                  in_acc, out_acc;
  logic                  pass_end, all_done;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_count_q <= 5'd3;
      link_len_q   <= 14'd4096;
      iter_q       <= 5'd10;
      base_q       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        fik_pkg::REG_LINK_COUNT: link_count_q <= pwdata[4:0];
        fik_pkg::REG_LINK_LEN:   link_len_q   <= pwdata[13:0];
        fik_pkg::REG_ITER:       iter_q       <= pwdata[4:0];
        fik_pkg::REG_BASE_X:     base_q.x     <= pwdata[CW-1:0];
        fik_pkg::REG_BASE_Y:     base_q.y     <= pwdata[CW-1:0];
        fik_pkg::REG_BASE_Z:     base_q.z     <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fik_pkg::REG_LINK_COUNT: prdata = {27'd0, link_count_q};
      fik_pkg::REG_LINK_LEN:   prdata = {18'd0, link_len_q};
      fik_pkg::REG_ITER:       prdata = {27'd0, iter_q};
      fik_pkg::REG_BASE_X:     prdata = 32'(base_q.x);
      fik_pkg::REG_BASE_Y:     prdata = 32'(base_q.y);
      fik_pkg::REG_BASE_Z:     prdata = 32'(base_q.z);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    rb.en   = cfg_wr && (reg_idx == fik_pkg::REG_LINK_COUNT ||
                         reg_idx == fik_pkg::REG_LINK_LEN);
    rb.base = base_q;
    rb.len  = (reg_idx == fik_pkg::REG_LINK_LEN) ? pwdata[13:0] : link_len_q;
  end

  always_comb begin
    if (link_count_q < 5'd2) begin
      n_act = 5'd2;
    end else if (link_count_q > 5'(fik_pkg::MaxLinks)) begin
      n_act = 5'(fik_pkg::MaxLinks);
    end else begin
      n_act = link_count_q;
    end
    last_idx = IW'(n_act - 5'd1);
    if (iter_q == 5'd0) begin
      iters_act = 5'd1;
    end else if (iter_q > 5'd20) begin
      iters_act = 5'd20;
    end else begin
      iters_act = iter_q;
    end
  end

  // ---------------------------------------------------------------- units
  fik_jmem u_jmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (jwr),
    .rb_i      (rb),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  fik_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .opa_i  (a_opa),
    .opb_i  (root_q),
    .done_o (a_done),
    .res_o  (a_res)
  );

  // ---------------------------------------------------------------- datapath helpers
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign k_idx   = fwd_q ? idx_q - IW'(1) : idx_q;
  assign a_idx   = fwd_q ? idx_q : idx_q - IW'(1);
  assign pass_end = fwd_q ? (idx_q == IW'(1)) : (idx_q == last_idx);
  assign all_done = !fwd_q && (it_q + 5'd1 == iters_act);

  always_comb begin
    unique case (j_q)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      default: mag_sel = mag_q[2];
    endcase
    mul_b = (state_q == fik_pkg::S_DMUL) ? MW'(link_len_q) : mag_sel;
    a_opa = (state_q == fik_pkg::S_SQRT) ? sum_q
          : fik_pkg::SumW'(prod_q[fik_pkg::DivW-1:0])
            + fik_pkg::SumW'(root_q >> 1);
  end

  assign dx = {rd_data.x[CW-1], rd_data.x} - {a_q.x[CW-1], a_q.x};
  assign dy = {rd_data.y[CW-1], rd_data.y} - {a_q.y[CW-1], a_q.y};
  assign dz = {rd_data.z[CW-1], rd_data.z} - {a_q.z[CW-1], a_q.z};

  always_comb begin
    logic signed [fik_pkg::WideW-1:0] ox, oy, oz;
    ox = $signed(fik_pkg::WideW'(quo_q[0]));
    oy = $signed(fik_pkg::WideW'(quo_q[1]));
    oz = $signed(fik_pkg::WideW'(quo_q[2]));
    if (zero_q) begin
      new_pos = a_q;
    end else begin
      new_pos.x = fik_pkg::sat_coord(fik_pkg::WideW'(a_q.x) + (neg_q[0] ? -ox : ox));
      new_pos.y = fik_pkg::sat_coord(fik_pkg::WideW'(a_q.y) + (neg_q[1] ? -oy : oy));
      new_pos.z = fik_pkg::sat_coord(fik_pkg::WideW'(a_q.z) + (neg_q[2] ? -oz : oz));
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fik_pkg::S_IDLE:   if (in_acc) state_d = fik_pkg::S_PIN;
      fik_pkg::S_PIN:    state_d = fik_pkg::S_RD_A;
      fik_pkg::S_RD_A:   state_d = fik_pkg::S_RD_K;
      fik_pkg::S_RD_K:   state_d = fik_pkg::S_DIFF;
      fik_pkg::S_DIFF: begin
        state_d = (dx == '0 && dy == '0 && dz == '0) ? fik_pkg::S_WR : fik_pkg::S_NORM;
      end
      fik_pkg::S_NORM: begin
        if (mag_q[0][MW-1] | mag_q[1][MW-1] | mag_q[2][MW-1]) state_d = fik_pkg::S_SQ;
      end
      fik_pkg::S_SQ:     if (j_q == 2'd3) state_d = fik_pkg::S_SQRT;
      fik_pkg::S_SQRT:   state_d = fik_pkg::S_SQRT_W;
      fik_pkg::S_SQRT_W: if (a_done) state_d = fik_pkg::S_DMUL;
      fik_pkg::S_DMUL:   state_d = fik_pkg::S_DST;
      fik_pkg::S_DST:    state_d = fik_pkg::S_DIV_W;
      fik_pkg::S_DIV_W: begin
        if (a_done) state_d = (j_q == 2'd2) ? fik_pkg::S_WR : fik_pkg::S_DMUL;
      end
      fik_pkg::S_WR: begin
        if (!pass_end) begin
          state_d = fik_pkg::S_RD_A;
        end else if (all_done) begin
          state_d = fik_pkg::S_OUT_RD;
        end else begin
          state_d = fik_pkg::S_PIN;
        end
      end
      fik_pkg::S_OUT_RD: state_d = fik_pkg::S_OUT_LD;
      fik_pkg::S_OUT_LD: state_d = fik_pkg::S_OUT_W;
      fik_pkg::S_OUT_W: begin
        if (out_acc) state_d = (out_idx_q == last_idx) ? fik_pkg::S_IDLE : fik_pkg::S_OUT_RD;
      end
      default:  state_d = fik_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs of the sequencer
  always_comb begin
    jwr.en    = 1'b0;
    jwr.addr  = k_idx;
    jwr.data  = new_pos;
    rd_addr   = a_idx;
    areq.start = 1'b0;
    areq.op    = fik_pkg::OP_SQRT;
    unique case (state_q)
      fik_pkg::S_PIN: begin
        jwr.en   = 1'b1;
        jwr.addr = fwd_q ? last_idx : '0;
        jwr.data = fwd_q ? tgt_q : base_q;
      end
      fik_pkg::S_RD_A:   rd_addr = a_idx;
      fik_pkg::S_RD_K:   rd_addr = k_idx;
      fik_pkg::S_SQRT:   areq.start = 1'b1;
      fik_pkg::S_DST: begin
        areq.start = 1'b1;
        areq.op    = fik_pkg::OP_DIV;
      end
      fik_pkg::S_WR:     jwr.en = 1'b1;
      fik_pkg::S_OUT_RD: rd_addr = out_idx_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fik_pkg::S_IDLE;
      fwd_q     <= 1'b1;
      idx_q     <= '0;
      it_q      <= '0;
      j_q       <= '0;
      out_idx_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        fik_pkg::S_IDLE: begin
          fwd_q <= 1'b1;
          it_q  <= '0;
        end
        fik_pkg::S_PIN:    idx_q <= fwd_q ? last_idx : IW'(1);
        fik_pkg::S_SQ:     j_q <= j_q + 2'd1;
        fik_pkg::S_SQRT_W: j_q <= '0;
        fik_pkg::S_DIV_W:  if (a_done) j_q <= j_q + 2'd1;
        fik_pkg::S_WR: begin
          if (!pass_end) begin
            idx_q <= fwd_q ? idx_q - IW'(1) : idx_q + IW'(1);
          end else if (fwd_q) begin
            fwd_q <= 1'b0;
          end else begin
            fwd_q     <= 1'b1;
            it_q      <= it_q + 5'd1;
            out_idx_q <= '0;
          end
        end
        fik_pkg::S_OUT_W:  if (out_acc) out_idx_q <= out_idx_q + IW'(1);
        default: ;
      endcase
      if (state_q == fik_pkg::S_DIFF) j_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q.x <= s_axis_tdata[23:0];
      tgt_q.y <= s_axis_tdata[47:24];
      tgt_q.z <= s_axis_tdata[71:48];
    end
    if (state_q == fik_pkg::S_RD_K) begin
      a_q <= rd_data;
    end
    if (state_q == fik_pkg::S_DIFF) begin
      neg_q     <= {dz[CW], dy[CW], dx[CW]};
      mag_q[0]  <= MW'(dx[CW] ? -dx : dx);
      mag_q[1]  <= MW'(dy[CW] ? -dy : dy);
      mag_q[2]  <= MW'(dz[CW] ? -dz : dz);
      zero_q    <= (dx == '0 && dy == '0 && dz == '0);
    end
    // normalize so the largest magnitude lands in [2^29, 2^30)
    if (state_q == fik_pkg::S_NORM &&
        !(mag_q[0][MW-1] | mag_q[1][MW-1] | mag_q[2][MW-1])) begin
      mag_q[0] <= mag_q[0] << 1;
      mag_q[1] <= mag_q[1] << 1;
      mag_q[2] <= mag_q[2] << 1;
    end
    if (state_q == fik_pkg::S_SQ || state_q == fik_pkg::S_DMUL) begin
      prod_q <= mag_sel * mul_b;
    end
    if (state_q == fik_pkg::S_SQ) begin
      sum_q <= (j_q == 2'd0) ? '0 : sum_q + fik_pkg::SumW'(prod_q);
    end
    if (state_q == fik_pkg::S_SQRT_W && a_done) begin
      root_q <= a_res[fik_pkg::RootW-1:0];
    end
    if (state_q == fik_pkg::S_DIV_W && a_done) begin
      unique case (j_q)
        2'd0:    quo_q[0] <= a_res[fik_pkg::QuotW-1:0];
        2'd1:    quo_q[1] <= a_res[fik_pkg::QuotW-1:0];
        default: quo_q[2] <= a_res[fik_pkg::QuotW-1:0];
      endcase
    end
    if (state_q == fik_pkg::S_OUT_LD) begin
      out_pos_q  <= rd_data;
      out_last_q <= (out_idx_q == last_idx);
    end
  end

  assign s_axis_tready = (state_q == fik_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == fik_pkg::S_OUT_W);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'd0, out_pos_q.z, out_pos_q.y, out_pos_q.x, out_idx_q};

  // ---------------------------------------------------------------- assertions
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (out_idx_q == last_idx))
    else $error("last flag on a joint that is not the final one");

  a_arith_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_done |-> (state_q == fik_pkg::S_SQRT_W || state_q == fik_pkg::S_DIV_W))
    else $error("arithmetic result arrived while the sequencer was not waiting");

  a_start_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    areq.start |=> !a_done)
    else $error("arithmetic unit finished in the cycle after a start");

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the fabrik inverse kinematics solver
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [3:0]  idx;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        last;
  } joint_pos_t;

  localparam int unsigned IdleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // target_x, target_y, target_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // joint_index, pos_x, pos_y, pos_z, zero fill
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fabrik_ik_solver uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // solver shadow state
  logic [4:0]  cfg_links;
  logic [13:0] cfg_len;
  logic [4:0]  cfg_iters;
  longint      base_px, base_py, base_pz;
  longint      jx[fik_pkg::MaxLinks], jy[fik_pkg::MaxLinks], jz[fik_pkg::MaxLinks];

  joint_pos_t  joint_q[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void rebuild_chain();
    for (int i = 0; i < fik_pkg::MaxLinks; i++) begin
      jx[i] = clamp24(base_px);
      jy[i] = clamp24(base_py + longint'(i) * longint'(cfg_len));
      jz[i] = clamp24(base_pz);
    end
  endfunction

  // move joint k to one link length from joint a
  function automatic void pull_joint(int k, int a);
    longint      d[3];
    logic [63:0] mag[3];
    logic        neg[3];
    logic [63:0] m, sum, root, q;
    d[0] = jx[k] - jx[a];
    d[1] = jy[k] - jy[a];
    d[2] = jz[k] - jz[a];
    m = 0;
    for (int j = 0; j < 3; j++) begin
      neg[j] = d[j] < 0;
      mag[j] = neg[j] ? -d[j] : d[j];
      if (mag[j] > m) m = mag[j];
    end
    if (m == 0) begin
      jx[k] = jx[a];
      jy[k] = jy[a];
      jz[k] = jz[a];
      return;
    end
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int j = 0; j < 3; j++) mag[j] = mag[j] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int j = 0; j < 3; j++) mag[j] = mag[j] << 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    root = int_sqrt(sum);
    for (int j = 0; j < 3; j++) begin
      q = (mag[j] * 64'(cfg_len) + (root >> 1)) / root;
      d[j] = neg[j] ? -longint'(q) : longint'(q);
    end
    jx[k] = clamp24(jx[a] + d[0]);
    jy[k] = clamp24(jy[a] + d[1]);
    jz[k] = clamp24(jz[a] + d[2]);
  endfunction

  function automatic void solve_target(logic [23:0] tx, logic [23:0] ty, logic [23:0] tz);
    int         n, iters;
    joint_pos_t p;
    n = (cfg_links < 2) ? 2
      : ((cfg_links > fik_pkg::MaxLinks) ? fik_pkg::MaxLinks : int'(cfg_links));
    iters = (cfg_iters < 1) ? 1 : ((cfg_iters > 20) ? 20 : int'(cfg_iters));
    for (int it = 0; it < iters; it++) begin
      jx[n-1] = sx24(tx);
      jy[n-1] = sx24(ty);
      jz[n-1] = sx24(tz);
      for (int i = n - 1; i > 0; i--) pull_joint(i - 1, i);
      jx[0] = clamp24(base_px);
      jy[0] = clamp24(base_py);
      jz[0] = clamp24(base_pz);
      for (int i = 1; i < n; i++) pull_joint(i, i - 1);
    end
    for (int i = 0; i < n; i++) begin
      p.idx = i[3:0];
      p.x = jx[i][23:0];
      p.y = jy[i][23:0];
      p.z = jz[i][23:0];
      p.last = (i == n - 1);
      joint_q.insert(joint_q.size(), p);
    end
  endfunction

  function automatic void apply_reg(fik_pkg::reg_e idx, logic [31:0] val);
    case (idx)
      fik_pkg::REG_LINK_COUNT: begin
        cfg_links = val[4:0];
        rebuild_chain();
      end
      fik_pkg::REG_LINK_LEN: begin
        cfg_len = val[13:0];
        rebuild_chain();
      end
      fik_pkg::REG_ITER: cfg_iters = val[4:0];
      fik_pkg::REG_BASE_X: base_px = sx24(val[23:0]);
      fik_pkg::REG_BASE_Y: base_py = sx24(val[23:0]);
      fik_pkg::REG_BASE_Z: base_pz = sx24(val[23:0]);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic reg_write(fik_pkg::reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_reg(idx, val);
  endtask

  // close any open burst, wait for every expected joint, then let the solver settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (joint_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_chain(logic [31:0] links, logic [31:0] len, logic [31:0] iters,
                           logic [23:0] bx, logic [23:0] by, logic [23:0] bz);
    drain();
    reg_write(fik_pkg::REG_BASE_X, {{8{bx[23]}}, bx});
    reg_write(fik_pkg::REG_BASE_Y, {{8{by[23]}}, by});
    reg_write(fik_pkg::REG_BASE_Z, {{8{bz[23]}}, bz});
    reg_write(fik_pkg::REG_ITER, iters);
    reg_write(fik_pkg::REG_LINK_COUNT, links);
    reg_write(fik_pkg::REG_LINK_LEN, len);
  endtask

  task automatic send_target(logic [23:0] tx, logic [23:0] ty, logic [23:0] tz);
    logic ok;
    s_axis_tdata <= {tz, ty, tx};
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    solve_target(tx, ty, tz);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 4);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [23:0] rnd24();
    return 24'($urandom);
  endfunction

  // receiver stall pattern: runs of full rate, coin flips and long stalls
  int stall_run = 0;
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(1, 30);
    end
    stall_run--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= (stall_run % 8) == 0;
    endcase
  end

  // result check, sampled mid-cycle where every signal is stable
  always @(negedge clk_i) begin
    joint_pos_t want;
    if (rst_ni && ((s_axis_tvalid && s_axis_tready) || psel)) idle_cycles = 0;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      idle_cycles = 0;
      if (joint_q.size() == 0) begin
        report_mismatch("unexpected joint", 32'(m_axis_tdata[3:0]), 32'd0);
      end else begin
        want = joint_q.pop_front();
        if (m_axis_tdata[3:0] !== want.idx)
          report_mismatch("joint_index", 32'(m_axis_tdata[3:0]), 32'(want.idx));
        if (m_axis_tdata[27:4] !== want.x)
          report_mismatch("pos_x", 32'(m_axis_tdata[27:4]), 32'(want.x));
        if (m_axis_tdata[51:28] !== want.y)
          report_mismatch("pos_y", 32'(m_axis_tdata[51:28]), 32'(want.y));
        if (m_axis_tdata[75:52] !== want.z)
          report_mismatch("pos_z", 32'(m_axis_tdata[75:52]), 32'(want.z));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_joint", 32'(m_axis_tlast), 32'(want.last));
      end
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic test_reset_chain();
    send_target(24'd0, 24'd4096, 24'd0);   // middle joint already on the target
    send_target(24'd0, 24'd8192, 24'd0);   // exactly at full reach
    send_target(24'd0, 24'd0, 24'd0);      // target on the base
    send_target(24'd12000, -24'sd3000, 24'd700);
  endtask

  task automatic test_coord_extremes();
    set_chain(3, 4096, 2, 24'd0, 24'd0, 24'd0);
    send_target(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_target(24'h800000, 24'h800000, 24'h800000);
    send_target(24'h7FFFFF, 24'h800000, 24'h000000);
    send_target(24'h000001, 24'hFFFFFF, 24'h000000);
    // base at the corner so joints saturate
    set_chain(4, 8192, 1, 24'h7FFFFF, 24'h7FFFF0, 24'h800000);
    send_target(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    send_target(24'h800000, 24'h000000, 24'h7FFFFF);
  endtask

  task automatic test_config_limits();
    set_chain(2, 2048, 1, 24'd0, 24'd0, 24'd0);
    send_target(24'd5000, 24'd1000, -24'sd2000);
    set_chain(16, 8192, 20, -24'sd100000, 24'd50000, 24'd3);
    send_target(24'd20000, 24'd90000, -24'sd40000);
    send_target(24'h800000, 24'h7FFFFF, 24'd0);
    // zero link count and iterations act as their lower limits, zero length collapses
    set_chain(0, 0, 0, 24'h800000, 24'h800000, 24'h800000);
    send_target(24'd77, 24'd0, 24'd0);
    send_target(24'h800000, 24'h800000, 24'h800000);
    set_chain(1, 16383, 31, 24'd4096, 24'd0, -24'sd4096);
    send_target(24'd30000, -24'sd30000, 24'd1);
    set_chain(31, 1, 2, 24'd0, 24'd0, 24'd0);
    send_target(24'd9, 24'd9, 24'd9);
    // base moves after the chain was built, without a rebuild
    set_chain(5, 4096, 3, 24'd0, 24'd0, 24'd0);
    drain();
    reg_write(fik_pkg::REG_BASE_X, 32'd8192);
    send_target(24'd0, 24'd16000, 24'd0);
  endtask

  task automatic test_random_targets();
    logic [23:0] bx, by, bz, tx, ty, tz;
    int          links;
    logic [31:0] reach;
    for (int ph = 0; ph < 10; ph++) begin
      bx = ($urandom_range(0, 3) == 0) ? rnd24() : 24'($urandom_range(0, 40000) - 20000);
      by = ($urandom_range(0, 3) == 0) ? rnd24() : 24'($urandom_range(0, 40000) - 20000);
      bz = ($urandom_range(0, 3) == 0) ? rnd24() : 24'($urandom_range(0, 40000) - 20000);
      links = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(2, 5);
      set_chain(links, $urandom_range(0, 16383), $urandom_range(1, 4), bx, by, bz);
      reach = 32'(links) * 32'(cfg_len);
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 4))
          0: begin
            tx = rnd24();
            ty = rnd24();
            tz = rnd24();
          end
          1: begin
            // aim at coordinates of current joints, each axis from its own random pick, to hit a zero-length difference
            tx = jx[$urandom_range(0, links - 1)][23:0];
            ty = jy[$urandom_range(0, links - 1)][23:0];
            tz = jz[$urandom_range(0, links - 1)][23:0];
          end
          default: begin
            tx = bx + 24'($urandom_range(0, 2 * reach) - reach);
            ty = by + 24'($urandom_range(0, 2 * reach) - reach);
            tz = bz + 24'($urandom_range(0, 2 * reach) - reach);
          end
        endcase
        send_target(tx, ty, tz);
      end
    end
  endtask

  initial begin
    cfg_links = 5'd3;
    cfg_len = 14'd4096;
    cfg_iters = 5'd10;
    base_px = 0;
    base_py = 0;
    base_pz = 0;
    rebuild_chain();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_chain();
    test_coord_extremes();
    test_config_limits();
    test_random_targets();
    drain();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fik_pkg.sv
rtl/core/fik_arith.sv
rtl/core/fik_jmem.sv
rtl/core/fabrik_ik_solver.sv
bench/testbench.sv
